// ----- sv/bmce_pkg.sv -----
// ----------------------------------------------------------------------------
// bmce_pkg: shared constants and types for the block mode chaining engine
// Lane geometry, chaining mode codes, register indexes and lane control.
// ----------------------------------------------------------------------------
package bmce_pkg;

  // Lane geometry
  localparam int LANE_CNT    = 8;             // byte lanes carried by one word
  localparam int BLOCK_BYTES = 8;             // lanes in use, 1..LANE_CNT
  localparam int LANE_W      = 8;
  localparam int BLOCK_W     = LANE_CNT * LANE_W;
  localparam int LANE_IDX_W  = 3;

  // Chaining mode codes; codes above MODE_CTR act as ECB
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_ECB = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CBC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CFB = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OFB = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CTR = 3'd4;

  // Register indexes on the configuration port (byte address = 8 * index)
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_KEY  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IV   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR  = 2'd3;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  localparam logic [LANE_W-1:0] CTR_RESTART = 8'd1;

  typedef logic [LANE_W-1:0] lane_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              dec;
  } lane_ctrl_t;

endpackage

// ----- sv/bmce_lane.sv -----
// ----------------------------------------------------------------------------
// bmce_lane: one byte lane of the chaining core
// Keyed XOR block function plus the per-lane chain and counter update.
// ----------------------------------------------------------------------------
module bmce_lane (
  input  bmce_pkg::lane_ctrl_t              ctrl,
  input  logic [bmce_pkg::LANE_IDX_W-1:0]   lane_idx,
  input  bmce_pkg::lane_t                   x,
  input  bmce_pkg::lane_t                   k,
  input  bmce_pkg::lane_t                   s,
  input  bmce_pkg::lane_t                   ctr_base,
  output bmce_pkg::lane_t                   r,
  output bmce_pkg::lane_t                   s_nxt
);

  bmce_pkg::lane_t ctr_lane;
  bmce_pkg::lane_t xsk;
  bmce_pkg::lane_t ofb;

  // Counter byte for this lane wraps mod 256
  assign ctr_lane = ctr_base + {{(bmce_pkg::LANE_W-bmce_pkg::LANE_IDX_W){1'b0}}, lane_idx};
  assign xsk      = x ^ s ^ k;
  assign ofb      = s ^ k;

  always_comb begin
    r     = x ^ k;
    s_nxt = s;
    case (ctrl.mode)
      bmce_pkg::MODE_CBC, bmce_pkg::MODE_CFB: begin
        r     = xsk;
        s_nxt = ctrl.dec ? x : xsk;
      end
      bmce_pkg::MODE_OFB: begin
        s_nxt = ofb;
        r     = x ^ ofb;
      end
      bmce_pkg::MODE_CTR: begin
        r = x ^ ctr_lane ^ k;
      end
      default: begin
        r     = x ^ k;
        s_nxt = s;
      end
    endcase
  end

endmodule

// ----- sv/bmce_merge.sv -----
// ----------------------------------------------------------------------------
// bmce_merge: lane merge and output register
// Pack lane results into one word and hold it until the sink takes it.
// ----------------------------------------------------------------------------
module bmce_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmce_pkg::lane_t               lane_r [bmce_pkg::LANE_CNT],
  input  logic                          load,
  output logic                          room,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bmce_pkg::BLOCK_W-1:0]  out_tdata   // block_out
);

  logic                         valid_r, valid_nxt;
  logic [bmce_pkg::BLOCK_W-1:0] data_r;
  logic [bmce_pkg::BLOCK_W-1:0] packed_blk;

  always_comb begin
    for (int i = 0; i < bmce_pkg::LANE_CNT; i++) begin
      packed_blk[i*bmce_pkg::LANE_W +: bmce_pkg::LANE_W] = lane_r[i];
    end
  end

  // Free when empty or draining this cycle
  assign room      = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= packed_blk;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// ----- sv/block_mode_chaining_engine.sv -----
// ----------------------------------------------------------------------------
// block_mode_chaining_engine: ECB/CBC/CFB/OFB/CTR chaining over byte lanes
// An accepted input word is valid at the output register in the next cycle.
// Throughput: one word per cycle while the output register has room; the chain and
// counter registers close a loop through the byte lanes, so back-to-back words chain.
// The output register frees in the same cycle the sink takes its word.
// Reset (synchronous, rst_n low): registers to zero, counter to one, output empty.
// ----------------------------------------------------------------------------
module block_mode_chaining_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bmce_pkg::BLOCK_W-1:0]     in_tdata,   // block_in
  input  logic                             in_tuser,   // restart
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bmce_pkg::BLOCK_W-1:0]     out_tdata,  // block_out
  // Configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [bmce_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [bmce_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [bmce_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  // Configuration registers
  logic [bmce_pkg::BLOCK_W-1:0]  key_r;
  logic [bmce_pkg::BLOCK_W-1:0]  iv_r;
  logic [bmce_pkg::MODE_W-1:0]   mode_r;
  logic                          dir_r;

  // Chaining state
  logic [bmce_pkg::BLOCK_W-1:0]  chain_r, chain_nxt;
  bmce_pkg::lane_t               ctr_r, ctr_nxt;

  logic                          cfg_wr;
  logic [bmce_pkg::REG_IDX_W-1:0] cfg_idx;
  logic                          in_acc;
  logic                          room;

  // Effective chain and counter after a restart
  logic [bmce_pkg::BLOCK_W-1:0]  chain_eff;
  bmce_pkg::lane_t               ctr_eff;
  bmce_pkg::lane_ctrl_t          ctrl;

  bmce_pkg::lane_t               lane_r   [bmce_pkg::LANE_CNT];
  bmce_pkg::lane_t               lane_s   [bmce_pkg::LANE_CNT];

  // --------------------------------------------------------------------------
  // Configuration port: writes land on the access phase, reads are immediate
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[bmce_pkg::CFG_ADDR_W-1 -: bmce_pkg::REG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      iv_r   <= '0;
      mode_r <= bmce_pkg::MODE_ECB;
      dir_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bmce_pkg::REG_KEY:  key_r  <= cfg_pwdata[bmce_pkg::BLOCK_W-1:0];
        bmce_pkg::REG_IV:   iv_r   <= cfg_pwdata[bmce_pkg::BLOCK_W-1:0];
        bmce_pkg::REG_MODE: mode_r <= cfg_pwdata[bmce_pkg::MODE_W-1:0];
        bmce_pkg::REG_DIR:  dir_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      bmce_pkg::REG_KEY:  cfg_prdata[bmce_pkg::BLOCK_W-1:0] = key_r;
      bmce_pkg::REG_IV:   cfg_prdata[bmce_pkg::BLOCK_W-1:0] = iv_r;
      bmce_pkg::REG_MODE: cfg_prdata[bmce_pkg::MODE_W-1:0]  = mode_r;
      bmce_pkg::REG_DIR:  cfg_prdata[0]                     = dir_r;
      default: cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input handshake: take a word whenever the output register has room
  // --------------------------------------------------------------------------
  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;

  // Restart reloads the chain from the IV and the counter to one, in front of
  // this word's processing
  assign chain_eff = in_tuser ? iv_r : chain_r;
  assign ctr_eff   = in_tuser ? bmce_pkg::CTR_RESTART : ctr_r;

  assign ctrl.mode = mode_r;
  assign ctrl.dec  = dir_r;

  // --------------------------------------------------------------------------
  // Byte lanes: active lanes run the core, unused lanes read as zero
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < bmce_pkg::LANE_CNT; g++) begin : g_lane
    if (g < bmce_pkg::BLOCK_BYTES) begin : g_act
      bmce_lane u_lane (
        .ctrl     (ctrl),
        .lane_idx (bmce_pkg::LANE_IDX_W'(g)),
        .x        (in_tdata[g*bmce_pkg::LANE_W +: bmce_pkg::LANE_W]),
        .k        (key_r[g*bmce_pkg::LANE_W +: bmce_pkg::LANE_W]),
        .s        (chain_eff[g*bmce_pkg::LANE_W +: bmce_pkg::LANE_W]),
        .ctr_base (ctr_eff),
        .r        (lane_r[g]),
        .s_nxt    (lane_s[g])
      );
    end else begin : g_off
      assign lane_r[g] = '0;
      assign lane_s[g] = '0;
    end
  end

  // Gather the per-lane chain updates
  always_comb begin
    for (int i = 0; i < bmce_pkg::LANE_CNT; i++) begin
      chain_nxt[i*bmce_pkg::LANE_W +: bmce_pkg::LANE_W] = lane_s[i];
    end
  end

  // Counter advances only on CTR words
  assign ctr_nxt = (mode_r == bmce_pkg::MODE_CTR) ? ctr_eff + 8'd1 : ctr_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
      ctr_r   <= bmce_pkg::CTR_RESTART;
    end else if (in_acc) begin
      chain_r <= chain_nxt;
      ctr_r   <= ctr_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Merge lanes into the output register
  // --------------------------------------------------------------------------
  bmce_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_r     (lane_r),
    .load       (in_acc),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An accepted word always shows up at the output on the next cycle
  a_acc_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted word did not reach the output register");

  // Counter holds outside CTR unless restarted
  a_ctr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tuser && mode_r != bmce_pkg::MODE_CTR) |=> ctr_r == $past(ctr_r))
    else $error("block counter moved outside CTR mode");

  // Restart outside CTR leaves the counter at one
  a_ctr_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser && mode_r != bmce_pkg::MODE_CTR) |=> ctr_r == bmce_pkg::CTR_RESTART)
    else $error("restart did not reload the block counter");

  // Chain register only moves on an accepted word
  a_chain_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && $past(rst_n)) |=> $stable(chain_r))
    else $error("chain register changed without an input word");

endmodule

// ----- tb/sv/block_mode_chaining_checker.sv -----
// ----------------------------------------------------------------------------
// block_mode_chaining_checker: scoreboard for the block mode chaining engine
// Snoops register writes and both streams, predicts each output word from its
// own copy of key, IV, mode, direction, chain block and counter, and compares
// words in order.
// ----------------------------------------------------------------------------
module block_mode_chaining_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bmce_pkg::BLOCK_W-1:0]    in_tdata,    // block_in
  input  logic                            in_tuser,    // restart
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bmce_pkg::BLOCK_W-1:0]    out_tdata,   // block_out
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic                            cfg_pready,
  input  logic [bmce_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bmce_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output int                              fail_count,
  output int                              pending
);

  localparam logic [bmce_pkg::BLOCK_W-1:0] LANE_MASK =
    (bmce_pkg::BLOCK_BYTES >= bmce_pkg::LANE_CNT)
      ? {bmce_pkg::BLOCK_W{1'b1}}
      : bmce_pkg::BLOCK_W'((65'd1 << (bmce_pkg::LANE_W * bmce_pkg::BLOCK_BYTES)) - 65'd1);

  logic [bmce_pkg::BLOCK_W-1:0]   key_reg, iv_reg, chain_reg;
  logic [bmce_pkg::MODE_W-1:0]    mode_reg;
  logic                           dec_reg;
  bmce_pkg::lane_t                block_ctr;

  logic [bmce_pkg::BLOCK_W-1:0]   expected_blocks[$];
  logic [bmce_pkg::BLOCK_W-1:0]   predicted_word, oldest_word;
  logic [bmce_pkg::REG_IDX_W-1:0] reg_idx;

  // Advance the chain state by one word and return the processed block.
  task automatic cipher_step(input logic [bmce_pkg::BLOCK_W-1:0] word_in,
                             input logic restart,
                             output logic [bmce_pkg::BLOCK_W-1:0] word_out);
    logic [bmce_pkg::BLOCK_W-1:0] x, k, ctr_blk;
    x = word_in & LANE_MASK;
    k = key_reg & LANE_MASK;
    if (restart) begin
      chain_reg = iv_reg & LANE_MASK;
      block_ctr = bmce_pkg::CTR_RESTART;
    end
    chain_reg = chain_reg & LANE_MASK;
    case (mode_reg)
      bmce_pkg::MODE_CBC, bmce_pkg::MODE_CFB: begin
        word_out  = x ^ chain_reg ^ k;
        chain_reg = dec_reg ? x : word_out;
      end
      bmce_pkg::MODE_OFB: begin
        chain_reg = chain_reg ^ k;
        word_out  = x ^ chain_reg;
      end
      bmce_pkg::MODE_CTR: begin
        for (int i = 0; i < bmce_pkg::LANE_CNT; i++)
          ctr_blk[i*bmce_pkg::LANE_W +: bmce_pkg::LANE_W] = bmce_pkg::lane_t'(block_ctr + i);
        word_out  = x ^ (ctr_blk & LANE_MASK) ^ k;
        block_ctr = block_ctr + 1'b1;
      end
      default: begin
        word_out = x ^ k;
      end
    endcase
    word_out = word_out & LANE_MASK;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_reg    = '0;
      iv_reg     = '0;
      mode_reg   = bmce_pkg::MODE_ECB;
      dec_reg    = 1'b0;
      chain_reg  = '0;
      block_ctr  = bmce_pkg::CTR_RESTART;
      fail_count = 0;
      expected_blocks.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        reg_idx = cfg_paddr[bmce_pkg::REG_IDX_W+2:3];
        case (reg_idx)
          bmce_pkg::REG_KEY:  key_reg  = cfg_pwdata[bmce_pkg::BLOCK_W-1:0];
          bmce_pkg::REG_IV:   iv_reg   = cfg_pwdata[bmce_pkg::BLOCK_W-1:0];
          bmce_pkg::REG_MODE: mode_reg = cfg_pwdata[bmce_pkg::MODE_W-1:0];
          bmce_pkg::REG_DIR:  dec_reg  = cfg_pwdata[0];
          default: ;
        endcase
      end
      // retire the output word before queuing the new one
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected output word %h", out_tdata);
          fail_count++;
        end else begin
          oldest_word = expected_blocks.pop_front();
          if (out_tdata !== oldest_word) begin
            if (fail_count < 10)
              $display("block_out mismatch: expected %h, got %h", oldest_word, out_tdata);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        cipher_step(in_tdata, in_tuser, predicted_word);
        expected_blocks = {expected_blocks, predicted_word};
      end
    end
    pending = expected_blocks.size();
  end

endmodule

// ----- tb/sv/tb_block_mode_chaining_engine.sv -----
// ----------------------------------------------------------------------------
// tb_block_mode_chaining_engine: stream test of the block mode chaining engine
// Runs a short directed pass over every chaining mode and direction, then
// random messages under changing key, IV, mode and back-pressure, including a
// long counter run that wraps; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_block_mode_chaining_engine;

  localparam int LIMIT = 200000;                // cycle budget for the whole run
  localparam logic [bmce_pkg::MODE_W-1:0] MODE_SPARE = 3'd7;   // undefined code, acts as ECB
  localparam int DIRECTED_SETS = 8;
  localparam int RANDOM_PHASES = 17;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [bmce_pkg::BLOCK_W-1:0]    in_tdata;     // block_in
  logic                            in_tuser;     // restart
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [bmce_pkg::BLOCK_W-1:0]    out_tdata;    // block_out
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [bmce_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [bmce_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [bmce_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  block_mode_chaining_engine dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  block_mode_chaining_checker checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random; one decision per falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [bmce_pkg::BLOCK_W-1:0] rand_block();
    return {$urandom, $urandom};
  endfunction

  // Pick one of the back-pressure profiles: none, sender, receiver, both.
  task automatic set_idling(input int sel);
    case (sel)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 52; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 52; end
      default: begin send_idle_pct = 28; stall_pct = 28; end
    endcase
  endtask

  // Offer one word, idling first at random; return at the falling edge after accept.
  task automatic send_word(input logic [bmce_pkg::BLOCK_W-1:0] data, input logic restart);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold the input low until every result is back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Two-phase register write: setup cycle, then access cycle.
  task automatic program_reg(input logic [bmce_pkg::REG_IDX_W-1:0] idx,
                             input logic [bmce_pkg::CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Quiesce the engine, then rewrite all four registers.
  task automatic load_settings(input logic [bmce_pkg::BLOCK_W-1:0] key,
                               input logic [bmce_pkg::BLOCK_W-1:0] iv,
                               input logic [bmce_pkg::MODE_W-1:0] mode, input logic dir);
    drain_results();
    repeat (2) @(negedge clk);
    program_reg(bmce_pkg::REG_KEY, key);
    program_reg(bmce_pkg::REG_IV, iv);
    program_reg(bmce_pkg::REG_MODE, bmce_pkg::CFG_DATA_W'(mode));
    program_reg(bmce_pkg::REG_DIR, bmce_pkg::CFG_DATA_W'(dir));
  endtask

  initial begin
    logic [bmce_pkg::MODE_W-1:0]  set_mode [DIRECTED_SETS];
    logic                         set_dir [DIRECTED_SETS];
    logic [bmce_pkg::BLOCK_W-1:0] key, iv, data;
    logic [bmce_pkg::MODE_W-1:0]  mode;
    logic                         dir, restart;
    int                           n_words;

    set_mode = '{bmce_pkg::MODE_CTR, bmce_pkg::MODE_CBC, bmce_pkg::MODE_CBC,
                 bmce_pkg::MODE_CFB, bmce_pkg::MODE_CFB, bmce_pkg::MODE_OFB,
                 bmce_pkg::MODE_ECB, MODE_SPARE};
    set_dir  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pass: every mode and direction, extreme blocks and keys.
    // The first two sets start without restart, so the counter and chain
    // block run from their reset values.
    set_idling(0);
    for (int s = 0; s < DIRECTED_SETS; s++) begin
      key = (s % 3 == 0) ? '0 : (s % 3 == 1) ? '1 : rand_block();
      iv  = (s % 2 == 1) ? '1 : rand_block();
      load_settings(key, iv, set_mode[s], set_dir[s]);
      send_word((s % 2 == 1) ? '1 : '0, s > 1);
      send_word((s % 2 == 1) ? '0 : '1, 1'b0);
      send_word(rand_block(), 1'b0);
    end

    // Random messages. The last phase is one long counter message that
    // wraps the block counter past 255.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idling((p + p / 8) % 4);
      if (p == RANDOM_PHASES - 1) begin
        mode    = bmce_pkg::MODE_CTR;
        dir     = 1'b1;
        n_words = 280;
      end else begin
        mode    = bmce_pkg::MODE_W'(p % 8);
        dir     = (p >= 8);
        n_words = 95;
      end
      key = (p == 0) ? '0 : (p == 1) ? '1 : rand_block();
      iv  = (p == 0) ? '1 : (p == 1) ? '0 : rand_block();
      load_settings(key, iv, mode, dir);
      for (int i = 0; i < n_words; i++) begin
        case ($urandom_range(0, 19))
          0:       data = '0;
          1:       data = '1;
          default: data = rand_block();
        endcase
        // messages of random length; the long counter run restarts only once
        if (i == 0)
          restart = (p != 0);
        else
          restart = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 11) == 0);
        // let the pipe run dry once in a while before carrying on
        if (p % 4 == 1 && i == n_words / 2)
          drain_results();
        send_word(data, restart);
      end
    end

    // Wait out the last results, then keep watching for stray words.
    drain_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
